// ----- sv/kle_pkg.sv -----
// Shared constants and item types for the keystroke line editor.
package kle_pkg;

  localparam int CAPACITY = 64;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_EOL = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] key_byte;
  } kle_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       last_of_line;
    logic       overflowed;
  } kle_out_t;

endpackage

// ----- sv/kle_store.sv -----
// Text store of the gap buffer: one write port, one registered read port.
module kle_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [kle_pkg::PTR_W-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [kle_pkg::PTR_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import kle_pkg::*;

  logic [7:0] mem [CAPACITY];

  // write one character
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/keystroke_line_editor.sv -----
// Gap-buffer line editor: keystroke edits and end-of-line drain around one text store.
//
// An item is taken when start is high and busy is low. Inserts, backspaces and
// ignored keys leave busy low. A cursor move ('<' or '>') raises busy: the store
// is read in the accept cycle and the character is written back to the other
// side of the gap in the next, since the store has a registered read and one
// write port. An end-of-line item keeps busy high while the line drains, one
// store read per character; results appear on result with strobe high for one
// cycle each, one per cycle and in line order, so the last one is shown in the
// first cycle in which busy is low again. An empty line gives a single marker
// result in the cycle after it is taken. The receiver cannot stall: each result
// is shown for exactly one cycle.
module keystroke_line_editor (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  kle_pkg::kle_in_t  key_item,
  output logic              busy,
  output logic              strobe,
  output kle_pkg::kle_out_t result
);
  import kle_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOVE  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] left_count, left_count_next;
  logic [CNT_W-1:0] right_count, right_count_next;
  logic             dropped_flag, dropped_flag_next;
  logic [CNT_W-1:0] drain_k, drain_k_next;
  logic [PTR_W-1:0] move_addr, move_addr_next;
  logic             out_strobe, out_strobe_next;
  logic             out_from_mem, out_from_mem_next;
  logic             out_last, out_last_next;
  logic             out_ovf, out_ovf_next;

  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [7:0]       wdata;
  logic [CNT_W-1:0] raddr_wide;
  logic [7:0]       rdata;
  logic [CNT_W-1:0] total;
  logic             accept;

  kle_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_wide[PTR_W-1:0]),
    .rdata (rdata)
  );

  assign total  = left_count + right_count;
  assign accept = start && (state == ST_IDLE);

  // sequence edits, moves and the drain
  always_comb begin
    state_next        = state;
    left_count_next   = left_count;
    right_count_next  = right_count;
    dropped_flag_next = dropped_flag;
    drain_k_next      = drain_k;
    move_addr_next    = move_addr;
    out_strobe_next   = 1'b0;
    out_from_mem_next = 1'b0;
    out_last_next     = 1'b0;
    out_ovf_next      = dropped_flag;
    we                = 1'b0;
    waddr             = left_count[PTR_W-1:0];
    wdata             = key_item.key_byte;
    raddr_wide        = left_count - ONE_CNT;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (key_item.command == CMD_EOL) begin
            if (total == '0) begin
              // empty line marker
              out_strobe_next   = 1'b1;
              out_last_next     = 1'b1;
              dropped_flag_next = 1'b0;
            end else begin
              drain_k_next = '0;
              state_next   = ST_DRAIN;
            end
          end else begin
            priority if (key_item.key_byte == KEY_LEFT) begin
              if (left_count != '0 && right_count < CAP_CNT) begin
                raddr_wide       = left_count - ONE_CNT;
                move_addr_next   = PTR_W'(CAP_CNT - ONE_CNT - right_count);
                left_count_next  = left_count - ONE_CNT;
                right_count_next = right_count + ONE_CNT;
                state_next       = ST_MOVE;
              end
            end else if (key_item.key_byte == KEY_RIGHT) begin
              if (right_count != '0 && left_count < CAP_CNT) begin
                raddr_wide       = CAP_CNT - right_count;
                move_addr_next   = left_count[PTR_W-1:0];
                left_count_next  = left_count + ONE_CNT;
                right_count_next = right_count - ONE_CNT;
                state_next       = ST_MOVE;
              end
            end else if (key_item.key_byte == KEY_BACK) begin
              if (left_count != '0) begin
                left_count_next = left_count - ONE_CNT;
              end
            end else begin
              // insert at the cursor, or drop and flag on a full buffer
              if (total < CAP_CNT) begin
                we              = 1'b1;
                waddr           = left_count[PTR_W-1:0];
                left_count_next = left_count + ONE_CNT;
              end else begin
                dropped_flag_next = 1'b1;
              end
            end
          end
        end
      end
      ST_MOVE: begin
        // write the read character across the gap
        we         = 1'b1;
        waddr      = move_addr;
        wdata      = rdata;
        state_next = ST_IDLE;
      end
      ST_DRAIN: begin
        // read left part, then right part past the gap
        if (drain_k < left_count) begin
          raddr_wide = drain_k;
        end else begin
          raddr_wide = drain_k + (CAP_CNT - total);
        end
        out_strobe_next   = 1'b1;
        out_from_mem_next = 1'b1;
        out_last_next     = (drain_k + ONE_CNT == total);
        drain_k_next      = drain_k + ONE_CNT;
        if (drain_k + ONE_CNT == total) begin
          left_count_next   = '0;
          right_count_next  = '0;
          dropped_flag_next = 1'b0;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      left_count   <= '0;
      right_count  <= '0;
      dropped_flag <= 1'b0;
      out_strobe   <= 1'b0;
    end else begin
      state        <= state_next;
      left_count   <= left_count_next;
      right_count  <= right_count_next;
      dropped_flag <= dropped_flag_next;
      out_strobe   <= out_strobe_next;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    drain_k      <= drain_k_next;
    move_addr    <= move_addr_next;
    out_from_mem <= out_from_mem_next;
    out_last     <= out_last_next;
    out_ovf      <= out_ovf_next;
  end

  // drive the result item
  assign busy                = (state != ST_IDLE);
  assign strobe              = out_strobe;
  assign result.char_out     = out_from_mem ? rdata : 8'h00;
  assign result.char_valid   = out_from_mem;
  assign result.last_of_line = out_last;
  assign result.overflowed   = out_ovf;

endmodule
